>>> rtl/mavg_pkg.sv
package mavg_pkg;

  localparam int WINDOW_MAX   = 64;
  localparam int SAMPLE_BITS  = 16;
  localparam int COUNT_W      = 7;
  localparam int SLOT_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int SUM_W        = SAMPLE_BITS + SLOT_W;
  localparam int WINDOW_RESET = 8;

endpackage

>>> rtl/mavg_ram.sv
module mavg_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/mavg_div.sv
module mavg_div (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [mavg_pkg::SUM_W-1:0]      dividend,
  input  logic [mavg_pkg::COUNT_W-1:0]           divisor,
  output logic                                   done,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] quotient
);

  import mavg_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic               busy_r;
  logic               done_r;
  logic               neg_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [SUM_W-1:0]   quo_r;
  logic [COUNT_W-1:0] rem_r;
  logic [COUNT_W-1:0] dvs_r;

  logic [SUM_W-1:0]   mag;
  logic [COUNT_W:0]   shifted;
  logic               ge;
  logic [COUNT_W:0]   diff;
  logic [SAMPLE_BITS-1:0] q_lo;

  // one quotient bit per cycle, restoring scheme on magnitudes
  always_comb begin
    mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
    shifted = {rem_r, quo_r[SUM_W-1]};
    ge      = shifted >= {1'b0, dvs_r};
    diff    = shifted - {1'b0, dvs_r};
    q_lo    = quo_r[SAMPLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == CNT_W'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt_r <= CNT_W'(SUM_W);
      quo_r <= mag;
      rem_r <= '0;
      dvs_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNT_W'(1);
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[COUNT_W-1:0] : shifted[COUNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = neg_r ? signed'(-q_lo) : signed'(q_lo);

endmodule

>>> rtl/moving_average_window.sv
// while the window fills, each accepted sample goes through the add, start,
// wait and done states; once it is full, a drop state first subtracts the
// oldest sample; samples go one at a time through the 22-step serial divider
// the next sample is taken while a finished result still waits on the output
// reset: window size 8, window empty; ring contents are not cleared
module moving_average_window (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mavg_pkg::SAMPLE_BITS-1:0] in_sample,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mavg_pkg::SAMPLE_BITS-1:0] out_mean,
  output logic [mavg_pkg::COUNT_W-1:0]            out_kept_count,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [mavg_pkg::COUNT_W-1:0]            cfg_window_size
);

  import mavg_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_DROP  = 6'b000010,
    ST_ADD   = 6'b000100,
    ST_START = 6'b001000,
    ST_WAIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [COUNT_W-1:0]      ws_r;
  logic [COUNT_W-1:0]      fill_r;
  logic [SLOT_W-1:0]       slot_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SAMPLE_BITS-1:0]  sample_r;
  logic                    out_valid_r;
  logic [SAMPLE_BITS-1:0]  out_mean_r;
  logic [COUNT_W-1:0]      out_count_r;

  logic                    in_acc;
  logic                    cfg_acc;
  logic                    full;
  logic [SLOT_W:0]         back;
  logic [SLOT_W-1:0]       oldest;
  logic [COUNT_W-1:0]      ws_clamped;
  logic [SAMPLE_BITS-1:0]  ram_rdata;
  logic                    div_done;
  logic signed [SAMPLE_BITS-1:0] div_q;
  logic                    out_free;
  logic signed [SUM_W-1:0] ext_old;
  logic signed [SUM_W-1:0] ext_new;

  assign cfg_ready = state_r == ST_IDLE;
  assign in_ready  = state_r == ST_IDLE && !cfg_valid;
  assign cfg_acc   = cfg_valid && cfg_ready;
  assign in_acc    = in_valid && in_ready;
  assign full      = fill_r >= ws_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    back = {1'b0, slot_r} + (SLOT_W+1)'(WINDOW_MAX) - (SLOT_W+1)'(ws_r);
    if (back >= (SLOT_W+1)'(WINDOW_MAX)) begin
      back = back - (SLOT_W+1)'(WINDOW_MAX);
    end
    oldest = back[SLOT_W-1:0];

    if (cfg_window_size == '0) begin
      ws_clamped = COUNT_W'(1);
    end else if (cfg_window_size > COUNT_W'(WINDOW_MAX)) begin
      ws_clamped = COUNT_W'(WINDOW_MAX);
    end else begin
      ws_clamped = cfg_window_size;
    end

    ext_old = SUM_W'(signed'(ram_rdata));
    ext_new = SUM_W'(signed'(sample_r));
  end

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (state_r == ST_ADD),
    .waddr (slot_r),
    .wdata (sample_r),
    .re    (in_acc),
    .raddr (oldest),
    .rdata (ram_rdata)
  );

  mavg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (state_r == ST_START),
    .dividend (sum_r),
    .divisor  (fill_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_acc) state_nxt = full ? ST_DROP : ST_ADD;
      ST_DROP:  state_nxt = ST_ADD;
      ST_ADD:   state_nxt = ST_START;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (div_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ws_r        <= COUNT_W'(WINDOW_RESET);
      fill_r      <= '0;
      slot_r      <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        ws_r   <= ws_clamped;
        fill_r <= '0;
        slot_r <= '0;
        sum_r  <= '0;
      end
      if (state_r == ST_DROP) begin
        sum_r  <= sum_r - ext_old;
        fill_r <= ws_r;
      end
      if (state_r == ST_ADD) begin
        sum_r  <= sum_r + ext_new;
        slot_r <= (slot_r == SLOT_W'(WINDOW_MAX - 1)) ? '0 : slot_r + SLOT_W'(1);
        if (fill_r < ws_r) begin
          fill_r <= fill_r + COUNT_W'(1);
        end
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r <= in_sample;
    end
    if (state_r == ST_DONE && out_free) begin
      out_mean_r  <= div_q;
      out_count_r <= fill_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_mean       = signed'(out_mean_r);
  assign out_kept_count = out_count_r;

endmodule
